FILE: design/fplog_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplog_pkg
// Shared widths and constants for the fixed-point logarithm pipeline.
// ----------------------------------------------------------------------------
package fplog_pkg;

  // Operand and normalized mantissa width.
  localparam int unsigned MANT_W = 32;

  // Width of the integer part of log2 (index of the top set bit).
  localparam int unsigned TOP_W = 5;

  // Width of each result field on the output stream.
  localparam int unsigned OUT_W = 21;

  // Output tdata width: two result fields padded up to whole bytes.
  localparam int unsigned OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // ln(2) in unsigned Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

endpackage : fplog_pkg
`default_nettype wire

FILE: design/fplog_square_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplog_square_stage
// One squaring round: squares the mantissa, renormalizes it and sets one
// fraction bit of the log2 accumulator, behind a registered stage.
// ----------------------------------------------------------------------------
module fplog_square_stage #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned ROUND         = 0
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic [fplog_pkg::MANT_W-1:0]                in_mant,
  input  wire logic [fplog_pkg::TOP_W+FRACTION_BITS-1:0]   in_acc,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [fplog_pkg::MANT_W-1:0]                     out_mant,
  output logic [fplog_pkg::TOP_W+FRACTION_BITS-1:0]        out_acc
);

  localparam int unsigned ACC_W   = fplog_pkg::TOP_W + FRACTION_BITS;
  localparam int unsigned BIT_POS = FRACTION_BITS - 1 - ROUND;

  logic [2*fplog_pkg::MANT_W-1:0] square;
  logic [fplog_pkg::MANT_W:0]     scaled;
  logic                           hit;
  logic [fplog_pkg::MANT_W-1:0]   mant_next;
  logic [ACC_W-1:0]               acc_next;

  // The square of a mantissa in [2^31, 2^32) shifted by 31 lies in
  // [2^31, 2^33); reaching 2^32 means this fraction bit is one.
  always_comb begin
    square    = {{fplog_pkg::MANT_W{1'b0}}, in_mant} * {{fplog_pkg::MANT_W{1'b0}}, in_mant};
    scaled    = square[2*fplog_pkg::MANT_W-1:fplog_pkg::MANT_W-1];
    hit       = scaled[fplog_pkg::MANT_W];
    mant_next = hit ? scaled[fplog_pkg::MANT_W:1] : scaled[fplog_pkg::MANT_W-1:0];
    acc_next  = in_acc;
    acc_next[BIT_POS] = in_acc[BIT_POS] | hit;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_mant <= mant_next;
      out_acc  <= acc_next;
    end
  end

endmodule : fplog_square_stage
`default_nettype wire

FILE: design/fixed_point_log_by_squaring_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_log_by_squaring_top
// Pipelined base-2 and natural logarithm of an unsigned 32-bit operand in
// unsigned fixed point, computed by repeated squaring of the mantissa.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  -----------------------------------
//  s_*       in         s_tvalid / s_tready  s_tdata[31:0]  = operand
//  m_*       out        m_tvalid / m_tready  m_tdata[20:0]  = log2_value,
//                                            m_tdata[41:21] = ln_value
//
// The pipeline accepts one transfer per cycle unless backpressure on m_tready
// stalls it. An operand lands in the normalize register at the edge that
// accepts it; then come one squaring multiplier stage per fraction bit, one
// ln2 product stage and the output register that adds the two product terms.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage holds its data while the stage after it is full and stalled,
// so backpressure on m_tready ripples back without losing or repeating items.
// ----------------------------------------------------------------------------
module fixed_point_log_by_squaring_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0: operand[31:0].
  input  wire logic [fplog_pkg::MANT_W-1:0]        s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // Fields from bit 0: log2_value[20:0], ln_value[41:21], zero padding.
  output logic [fplog_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  localparam int unsigned ACC_W = fplog_pkg::TOP_W + FRACTION_BITS;

  // Stage k register feeds squaring round k; index FRACTION_BITS is the
  // output of the last round.
  logic                         valid_s [0:FRACTION_BITS];
  logic                         ready_s [0:FRACTION_BITS];
  logic [fplog_pkg::MANT_W-1:0] mant_s  [0:FRACTION_BITS];
  logic [ACC_W-1:0]             acc_s   [0:FRACTION_BITS];

  // --------------------------------------------------------------------------
  // Normalize stage: find the top set bit and shift it to bit 31. Operands
  // zero and one give a top index of zero and a mantissa that never grows,
  // so both come out as zero without a special path.
  // --------------------------------------------------------------------------
  logic [fplog_pkg::TOP_W-1:0]  top_index;
  logic [fplog_pkg::TOP_W-1:0]  shift_amount;
  logic [fplog_pkg::MANT_W-1:0] norm_mant;

  always_comb begin
    top_index = '0;
    for (int i = 0; i < fplog_pkg::MANT_W; i++) begin
      if (s_tdata[i]) begin
        top_index = fplog_pkg::TOP_W'(i);
      end
    end
    shift_amount = fplog_pkg::TOP_W'(fplog_pkg::MANT_W - 1) - top_index;
    norm_mant    = s_tdata << shift_amount;
  end

  assign s_tready = !valid_s[0] || ready_s[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s[0] <= 1'b0;
    end else if (s_tready) begin
      valid_s[0] <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      mant_s[0] <= norm_mant;
      acc_s[0]  <= ACC_W'(top_index) << FRACTION_BITS;
    end
  end

  // --------------------------------------------------------------------------
  // Squaring rounds, one fraction bit each, most significant first.
  // --------------------------------------------------------------------------
  for (genvar r = 0; r < FRACTION_BITS; r++) begin : g_round
    fplog_square_stage #(
      .FRACTION_BITS(FRACTION_BITS),
      .ROUND        (r)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_s[r]),
      .in_ready (ready_s[r]),
      .in_mant  (mant_s[r]),
      .in_acc   (acc_s[r]),
      .out_valid(valid_s[r+1]),
      .out_ready(ready_s[r+1]),
      .out_mant (mant_s[r+1]),
      .out_acc  (acc_s[r+1])
    );
  end

  // --------------------------------------------------------------------------
  // Natural log scaling. The log2 word is split at bit 32; the high part
  // times ln2 plus the upper half of the low part times ln2 equals the
  // truncated product shifted by 32. Only the low output bits are kept.
  // --------------------------------------------------------------------------
  logic [63:0]              log2_wide;
  logic [63:0]              lo_product;
  logic [63:0]              hi_product;
  logic                     scale_valid;
  logic                     scale_ready;
  logic [fplog_pkg::OUT_W-1:0] scale_log2;
  logic [fplog_pkg::OUT_W-1:0] scale_lo;
  logic [fplog_pkg::OUT_W-1:0] scale_hi;

  always_comb begin
    log2_wide  = 64'(acc_s[FRACTION_BITS]);
    lo_product = {32'd0, log2_wide[31:0]}  * {32'd0, fplog_pkg::LN2_Q32};
    hi_product = {32'd0, log2_wide[63:32]} * {32'd0, fplog_pkg::LN2_Q32};
  end

  assign ready_s[FRACTION_BITS] = !scale_valid || scale_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_valid <= 1'b0;
    end else if (ready_s[FRACTION_BITS]) begin
      scale_valid <= valid_s[FRACTION_BITS];
    end
    if (ready_s[FRACTION_BITS] && valid_s[FRACTION_BITS]) begin
      scale_log2 <= log2_wide[fplog_pkg::OUT_W-1:0];
      scale_lo   <= lo_product[32+fplog_pkg::OUT_W-1:32];
      scale_hi   <= hi_product[fplog_pkg::OUT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: sums the two ln2 terms and holds the result until the
  // transfer on the master side completes.
  // --------------------------------------------------------------------------
  logic [fplog_pkg::OUT_W-1:0] ln_sum;

  assign ln_sum      = scale_hi + scale_lo;
  assign scale_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (scale_ready) begin
      m_tvalid <= scale_valid;
    end
    if (scale_ready && scale_valid) begin
      m_tdata <= fplog_pkg::OUT_TDATA_W'({ln_sum, scale_log2});
    end
  end

endmodule : fixed_point_log_by_squaring_top
`default_nettype wire
